// ===== rtl/bqlp_pkg.sv =====
// shared types and constants for the biquad low-pass with warm-up
package bqlp_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 18;
    localparam int FRAC_BITS = 16;
    localparam int WARM_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = COEF_W + SAMPLE_W;
    localparam int ACC_W     = PROD_W + 4;
    localparam int RND_W     = ACC_W - FRAC_BITS;

    localparam logic signed [COEF_W-1:0] COEF_B0_RESET = COEF_W'(65536);
    localparam logic [WARM_W-1:0] WARMUP_RESET = WARM_W'(500);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_B0   = 3'd0,
        REG_COEF_B1   = 3'd1,
        REG_COEF_B2   = 3'd2,
        REG_COEF_A1   = 3'd3,
        REG_COEF_A2   = 3'd4,
        REG_WARMUP_LEN = 3'd5
    } t_reg_idx;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;

    typedef struct packed {
        t_coef b0;
        t_coef b1;
        t_coef b2;
        t_coef a1;
        t_coef a2;
    } t_coefs;

endpackage

// ===== rtl/biquad_lowpass_with_warmup.sv =====
// top level: request handshakes, input and result registers around the filter core
//
// second-order low-pass biquad (direct form I) with a warm-up bypass
// input channel: i_valid / o_ready with i_sample_in, one signed 16-bit sample
// per request; result channel: o_valid / i_ready with o_sample_out and
// o_bypassed, exactly one result per input request, in order
// config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// o_cfg_ready is always high; writes are meant only while the block is idle
// pipeline: input register -> five products, sum, round, saturate -> result
// register; an accepted request moves from the input register into the result
// register when the result slot is free or is being emptied
// throughput: one request per cycle unless the result channel stalls; the feedback
// path (previous outputs into the products) is combinational between the registers
// stall: when the result register is full and i_ready is low, one more request
// is held in the input register, after which o_ready drops
// reset (synchronous, active low): both registers empty, histories and the
// warm-up counter cleared, coefficients b0 = 1.0, others 0, warm-up 500
module biquad_lowpass_with_warmup (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input request channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [15:0]             i_sample_in,
    // result channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [15:0]             o_sample_out,
    output logic                           o_bypassed,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bqlp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bqlp_pkg::COEF_W-1:0]    i_cfg_data
);
    import bqlp_pkg::*;

    // input register
    logic    r_in_valid;
    t_sample r_in_sample;

    // result register
    logic    r_out_valid;
    t_sample r_out_sample;
    logic    r_out_bypassed;

    t_coefs            coefs;
    logic [WARM_W-1:0] warmup_length;
    t_sample           core_sample;
    logic              core_bypassed;
    logic              advance;
    logic              in_take;

    assign o_cfg_ready = 1'b1;

    bqlp_cfg_regs u_cfg_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_coefs         (coefs),
        .o_warmup_length (warmup_length)
    );

    // the item in the input register moves on when the result slot is free
    // or is being emptied this cycle
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign in_take = i_valid && o_ready;

    bqlp_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (advance),
        .i_sample        (r_in_sample),
        .i_coefs         (coefs),
        .i_warmup_length (warmup_length),
        .o_sample        (core_sample),
        .o_bypassed      (core_bypassed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_sample <= i_sample_in;
        end
        if (advance) begin
            r_out_sample   <= core_sample;
            r_out_bypassed <= core_bypassed;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_bypassed   = r_out_bypassed;

`ifndef SYNTHESIS
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_in_valid && r_out_valid && !i_ready)
        else $error("input stalled without a full pipeline");
    a_load_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_valid && o_sample_out == $past(core_sample))
        else $error("result register not loaded on advance");
    a_take_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_valid && r_in_sample == $past(i_sample_in))
        else $error("input register not loaded on request");
`endif

endmodule

// ===== rtl/bqlp_cfg_regs.sv =====
// configuration register file: coefficients and warm-up length
module bqlp_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [bqlp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bqlp_pkg::COEF_W-1:0]    i_cfg_data,
    output bqlp_pkg::t_coefs               o_coefs,
    output logic [bqlp_pkg::WARM_W-1:0]    o_warmup_length
);
    import bqlp_pkg::*;

    t_coefs            r_coefs;
    t_coefs            n_coefs;
    logic [WARM_W-1:0] r_warmup_length;
    logic [WARM_W-1:0] n_warmup_length;

    always_comb begin
        n_coefs         = r_coefs;
        n_warmup_length = r_warmup_length;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_COEF_B0:    n_coefs.b0 = t_coef'(i_cfg_data);
                REG_COEF_B1:    n_coefs.b1 = t_coef'(i_cfg_data);
                REG_COEF_B2:    n_coefs.b2 = t_coef'(i_cfg_data);
                REG_COEF_A1:    n_coefs.a1 = t_coef'(i_cfg_data);
                REG_COEF_A2:    n_coefs.a2 = t_coef'(i_cfg_data);
                REG_WARMUP_LEN: n_warmup_length = i_cfg_data[WARM_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0      <= COEF_B0_RESET;
            r_coefs.b1      <= '0;
            r_coefs.b2      <= '0;
            r_coefs.a1      <= '0;
            r_coefs.a2      <= '0;
            r_warmup_length <= WARMUP_RESET;
        end else begin
            r_coefs         <= n_coefs;
            r_warmup_length <= n_warmup_length;
        end
    end

    assign o_coefs         = r_coefs;
    assign o_warmup_length = r_warmup_length;

endmodule

// ===== rtl/bqlp_core.sv =====
// filter arithmetic, sample histories and warm-up counter
module bqlp_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  bqlp_pkg::t_sample           i_sample,
    input  bqlp_pkg::t_coefs            i_coefs,
    input  logic [bqlp_pkg::WARM_W-1:0] i_warmup_length,
    output bqlp_pkg::t_sample           o_sample,
    output logic                        o_bypassed
);
    import bqlp_pkg::*;

    t_sample           r_x1;
    t_sample           r_x2;
    t_sample           r_y1;
    t_sample           r_y2;
    logic [WARM_W-1:0] r_warm_count;
    logic [WARM_W-1:0] n_warm_count;

    logic signed [PROD_W-1:0] p_b0;
    logic signed [PROD_W-1:0] p_b1;
    logic signed [PROD_W-1:0] p_b2;
    logic signed [PROD_W-1:0] p_a1;
    logic signed [PROD_W-1:0] p_a2;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic signed [RND_W-1:0]  rnd;
    t_sample                  filt;
    logic                     bypass;

    assign p_b0 = i_coefs.b0 * i_sample;
    assign p_b1 = i_coefs.b1 * r_x1;
    assign p_b2 = i_coefs.b2 * r_x2;
    assign p_a1 = i_coefs.a1 * r_y1;
    assign p_a2 = i_coefs.a2 * r_y2;

    assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
               - ACC_W'(p_a1) - ACC_W'(p_a2);

    // round half up, then floor by arithmetic shift
    assign acc_rnd = acc + (ACC_W'(1) <<< (FRAC_BITS - 1));
    assign rnd     = acc_rnd[ACC_W-1:FRAC_BITS];

    always_comb begin
        if (rnd > RND_W'(SAMPLE_MAX)) begin
            filt = SAMPLE_MAX;
        end else if (rnd < RND_W'(SAMPLE_MIN)) begin
            filt = SAMPLE_MIN;
        end else begin
            filt = rnd[SAMPLE_W-1:0];
        end
    end

    assign bypass = r_warm_count < i_warmup_length;

    always_comb begin
        n_warm_count = r_warm_count;
        if (i_advance && bypass) begin
            n_warm_count = r_warm_count + WARM_W'(1);
        end
    end

    assign o_sample   = bypass ? i_sample : filt;
    assign o_bypassed = bypass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1         <= '0;
            r_x2         <= '0;
            r_y1         <= '0;
            r_y2         <= '0;
            r_warm_count <= '0;
        end else begin
            r_warm_count <= n_warm_count;
            if (i_advance) begin
                r_x2 <= r_x1;
                r_x1 <= i_sample;
                r_y2 <= r_y1;
                r_y1 <= o_sample;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && bypass |=> r_warm_count == $past(r_warm_count) + WARM_W'(1))
        else $error("warm-up counter did not step on a bypassed sample");
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_advance && bypass) |=> $stable(r_warm_count))
        else $error("warm-up counter moved without a bypassed sample");
    a_hist_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance |=> r_x1 == $past(i_sample) && r_y1 == $past(o_sample)
                      && r_y2 == $past(r_y1))
        else $error("histories did not shift");
    a_bypass_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bypass |-> o_sample == i_sample)
        else $error("bypassed sample altered");
`endif

endmodule
